// File: sv/paq_pkg.sv
// ----------------------------------------------------------------------------
// paq_pkg: shared types and constants of the paced action queue
// Widths, action codes, pipeline stage and configuration types, a pointer helper.
// ----------------------------------------------------------------------------
`default_nettype none

package paq_pkg;

   localparam int QUEUE_DEPTH     = 8;
   localparam int PAYLOAD_WIDTH   = 32;

   localparam int ACTION_WIDTH    = 2;
   localparam int NOW_WIDTH       = 63;
   localparam int CFG_WIDTH       = 40;
   localparam int DEADLINE_WIDTH  = 64;
   localparam int REMAINING_WIDTH = 4;
   localparam int PTR_WIDTH       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_ADDR_WIDTH  = 4;

   localparam logic [CFG_WIDTH-1:0] PACING_RESET  = CFG_WIDTH'(10000000);
   localparam logic [CFG_WIDTH-1:0] DAMPING_RESET = CFG_WIDTH'(500000000);

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_TIMER   = 2'd1,
      ACT_DAMP    = 2'd2
   } action_type;

   typedef enum logic {
      REG_PACING  = 1'b0,
      REG_DAMPING = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] pacing_interval;
      logic [CFG_WIDTH-1:0] damping_timeout;
   } cfg_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0]   action;
      logic [PAYLOAD_WIDTH-1:0]  payload;
      logic [NOW_WIDTH-1:0]      now;
      logic [DEADLINE_WIDTH-1:0] deadline_sum;
   } stage_type;

   function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] p);
      ptr_next = (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

`default_nettype wire

// File: sv/paq_req_if.sv
// ----------------------------------------------------------------------------
// paq_req_if: request channel of the paced action queue
// Valid/ready handshake carrying action, payload and timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface paq_req_if;
   import paq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_WIDTH-1:0]  action;
   logic [PAYLOAD_WIDTH-1:0] payload;
   logic [NOW_WIDTH-1:0]     now;

   modport source (output valid, action, payload, now, input ready);
   modport sink   (input valid, action, payload, now, output ready);
endinterface

`default_nettype wire

// File: sv/paq_rsp_if.sv
// ----------------------------------------------------------------------------
// paq_rsp_if: response channel of the paced action queue
// Valid/ready handshake carrying the released word and the remaining count.
// ----------------------------------------------------------------------------
`default_nettype none

interface paq_rsp_if;
   import paq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [PAYLOAD_WIDTH-1:0]   emitted_payload;
   logic [REMAINING_WIDTH-1:0] remaining;

   modport source (output valid, emitted_payload, remaining, input ready);
   modport sink   (input valid, emitted_payload, remaining, output ready);
endinterface

`default_nettype wire

// File: sv/paq_csr.sv
// ----------------------------------------------------------------------------
// paq_csr: configuration registers
// APB-style write/read of the pacing interval and damping timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [paq_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [paq_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [paq_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                     pready,
   output paq_pkg::cfg_type                         cfg
);
   import paq_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type sel;
   logic          wr_en;

   // registers sit 8 bytes apart
   assign sel    = reg_index_type'(paddr[3]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_PACING:  cfg_in.pacing_interval = pwdata[CFG_WIDTH-1:0];
            REG_DAMPING: cfg_in.damping_timeout = pwdata[CFG_WIDTH-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_PACING:  prdata = CSR_DATA_WIDTH'(cfg_ff.pacing_interval);
         REG_DAMPING: prdata = CSR_DATA_WIDTH'(cfg_ff.damping_timeout);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pacing_interval <= PACING_RESET;
         cfg_ff.damping_timeout <= DAMPING_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: sv/paq_ingress.sv
// ----------------------------------------------------------------------------
// paq_ingress: input register
// Captures a request transaction and precomputes the candidate deadline.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_ingress (
   input  wire logic                              clock,
   input  wire logic                              reset,
   paq_req_if.sink                                req_chan,
   input  wire logic [paq_pkg::CFG_WIDTH-1:0]     pacing_interval,
   input  wire logic                              advance,
   output logic                                   stage_valid,
   output paq_pkg::stage_type                     stage
);
   import paq_pkg::*;

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic      accept;

   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // 63-bit time plus 40-bit interval cannot overflow 64 bits
   always_comb begin
      stage_in.action       = req_chan.action;
      stage_in.payload      = req_chan.payload;
      stage_in.now          = req_chan.now;
      stage_in.deadline_sum = DEADLINE_WIDTH'(req_chan.now)
                            + DEADLINE_WIDTH'(pacing_interval);
      valid_in = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

`default_nettype wire

// File: sv/paq_engine.sv
// ----------------------------------------------------------------------------
// paq_engine: queue state and release logic
// Ring buffer, pacing timer, damping flush and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire paq_pkg::cfg_type              cfg,
   input  wire logic                          stage_valid,
   input  wire paq_pkg::stage_type            stage,
   output logic                               advance,
   paq_rsp_if.source                          rsp_chan
);
   import paq_pkg::*;

   logic [PAYLOAD_WIDTH-1:0]   slots_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]       rd_ff, rd_in;
   logic [PTR_WIDTH-1:0]       wr_ff, wr_in;
   logic [COUNT_WIDTH-1:0]     occ_ff, occ_in;
   logic [NOW_WIDTH-1:0]       last_ff, last_in;
   logic                       armed_ff, armed_in;
   logic [DEADLINE_WIDTH-1:0]  deadline_ff, deadline_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [PAYLOAD_WIDTH-1:0]   rsp_word_ff;
   logic [REMAINING_WIDTH-1:0] rsp_rem_ff;

   logic                       slot_we;
   logic                       res_fire;
   logic [COUNT_WIDTH-1:0]     occ_dec;
   logic [NOW_WIDTH-1:0]       silence;
   logic                       expired;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign occ_dec = occ_ff - 1'b1;
   assign silence = stage.now - last_ff;
   assign expired = {1'b0, stage.now} >= deadline_ff;

   always_comb begin
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      occ_in      = occ_ff;
      last_in     = last_ff;
      armed_in    = armed_ff;
      deadline_in = deadline_ff;
      slot_we     = 1'b0;
      res_fire    = 1'b0;
      if (stage_valid && advance) begin
         case (action_type'(stage.action))
            ACT_ENQUEUE: begin
               last_in = stage.now;
               slot_we = 1'b1;
               wr_in   = ptr_next(wr_ff);
               if (occ_ff == COUNT_WIDTH'(QUEUE_DEPTH)) begin
                  // full: oldest entry goes, count unchanged
                  rd_in = ptr_next(rd_ff);
               end else begin
                  occ_in = occ_ff + 1'b1;
                  if (occ_ff == '0) begin
                     armed_in    = 1'b1;
                     deadline_in = stage.deadline_sum;
                  end
               end
            end
            ACT_TIMER: begin
               if (armed_ff && expired) begin
                  if (occ_ff == '0) begin
                     armed_in = 1'b0;
                  end else begin
                     res_fire = 1'b1;
                     rd_in    = ptr_next(rd_ff);
                     occ_in   = occ_dec;
                     if (occ_dec != '0) begin
                        deadline_in = stage.deadline_sum;
                     end else begin
                        armed_in = 1'b0;
                     end
                  end
               end
            end
            ACT_DAMP: begin
               if (occ_ff != '0 && last_ff != '0 && stage.now >= last_ff
                   && silence >= NOW_WIDTH'(cfg.damping_timeout)) begin
                  rd_in    = '0;
                  wr_in    = '0;
                  occ_in   = '0;
                  armed_in = 1'b0;
               end
            end
            default: begin
               rd_in = rd_ff;
            end
         endcase
      end
      rsp_valid_in = res_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff        <= '0;
         wr_ff        <= '0;
         occ_ff       <= '0;
         last_ff      <= '0;
         armed_ff     <= 1'b0;
         deadline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         occ_ff       <= occ_in;
         last_ff      <= last_in;
         armed_ff     <= armed_in;
         deadline_ff  <= deadline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slots_ff[wr_ff] <= stage.payload;
      end
      if (res_fire) begin
         rsp_word_ff <= slots_ff[rd_ff];
         rsp_rem_ff  <= REMAINING_WIDTH'(occ_dec);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.emitted_payload = rsp_word_ff;
   assign rsp_chan.remaining       = rsp_rem_ff;

endmodule

`default_nettype wire

// File: sv/paced_action_queue_unit.sv
// ----------------------------------------------------------------------------
// paced_action_queue_unit: paced drop-oldest action queue
// Queues action words and releases at most one per pacing interval.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one transaction per event: enqueue a word, check the
//    pacing timer, or check for input silence (damping). Each carries the
//    current timestamp.
//  - rsp_chan delivers a word released by a timer check that fired, with the
//    number of entries still queued. Other transactions give no response.
//  - A transaction accepted into the input register is executed when the
//    engine advances, which also loads its response into the response
//    register; the response is valid from then until it is taken.
//  - Throughput: one transaction per cycle while no response is stalled;
//    the queue state is updated between the input and response registers.
//  - Receiver stall: the response register holds; the input register still
//    takes one transaction, after which req_chan.ready drops until the
//    response is taken.
//  - Reset (synchronous): queue empty, timer disarmed, no input seen,
//    registers at their defaults. Queue contents are not cleared.
//  - Registers (APB, 64-bit data): 0x0 pacing interval, 0x8 damping timeout.
//    Write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module paced_action_queue_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   paq_req_if.sink                                  req_chan,
   paq_rsp_if.source                                rsp_chan,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [paq_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [paq_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [paq_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                     pready
);
   import paq_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_valid;
   logic      advance;   // engine can take the staged transaction this cycle

   // configuration registers
   paq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register; also forms now + interval ahead of the state update
   paq_ingress u_ingress (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .pacing_interval (cfg.pacing_interval),
      .advance         (advance),
      .stage_valid     (stage_valid),
      .stage           (stage)
   );

   // queue, timer and damping state plus the response register
   paq_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .advance     (advance),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

// File: sv/paq_checker.sv
// ----------------------------------------------------------------------------
// paq_checker: port-level checks of the paced action queue
// Reset behaviour, stall holding, back-pressure origin and count bound.
// ----------------------------------------------------------------------------
`default_nettype none

module paq_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [paq_pkg::PAYLOAD_WIDTH-1:0]    rsp_payload,
   input wire logic [paq_pkg::REMAINING_WIDTH-1:0]  rsp_remaining
);
   import paq_pkg::*;

   // after reset nothing is pending on either side
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("paq: state not cleared by reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_payload) && $stable(rsp_remaining)))
      else $error("paq: stalled response changed");

   // request back-pressure only comes from a stalled response
   a_bp_origin: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("paq: request stalled without response back-pressure");

   // after a release fewer than a full queue remain
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && QUEUE_DEPTH <= 16) |-> (int'(rsp_remaining) < QUEUE_DEPTH))
      else $error("paq: remaining count out of range");

endmodule

bind paced_action_queue_unit paq_checker u_paq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_payload   (rsp_chan.emitted_payload),
   .rsp_remaining (rsp_chan.remaining)
);

`default_nettype wire
